// ===== design/ufc_pkg.sv =====
package ufc_pkg;

    localparam int QUEUE_COUNT = 64;
    localparam logic [8:0] QUEUE_LIMIT = 9'(QUEUE_COUNT);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  IHL_PLAIN   = 4'd5;
    localparam logic [5:0]  MIN_FRAME_LEN = 6'd42;
    localparam logic [5:0]  POS_MAX       = 6'd63;

    localparam logic [5:0] POS_ETYPE_HI = 6'd12;
    localparam logic [5:0] POS_ETYPE_LO = 6'd13;
    localparam logic [5:0] POS_IHL      = 6'd14;
    localparam logic [5:0] POS_PROTO    = 6'd23;
    localparam logic [5:0] POS_DPORT_HI = 6'd36;
    localparam logic [5:0] POS_DPORT_LO = 6'd37;

    localparam int EVQ_DEPTH   = 2;
    localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
    localparam int EVQ_COUNT_W = $clog2(EVQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [5:0] rx_queue;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        logic [5:0]  target_queue;
        logic [63:0] redirected_count;
        logic [63:0] mismatch_count;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_UNCOUNTED,
        CLS_MISMATCH,
        CLS_MATCH
    } t_cls;

    // One classified frame handed from the parser to the counter stage
    typedef struct packed {
        t_cls       cls;
        logic       queue_ok;
        logic [5:0] queue;
    } t_event;

    typedef struct packed {
        logic valid;
        logic full;
    } t_evq_status;

endpackage

// ===== design/ufc_front.sv =====
module ufc_front
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_accept,
    input  t_in_item    i_item,
    output logic        o_push,
    output t_event      o_event
);

    logic [15:0] r_match_port;
    logic [5:0]  r_pos, n_pos;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_ihl, n_ihl;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_dport, n_dport;

    logic [5:0]  cap_pos;
    logic [15:0] cap_ether_type;
    logic [3:0]  cap_ihl;
    logic [7:0]  cap_proto;
    logic [15:0] cap_dport;
    logic        frame_ok;

    // captures including the current byte
    always_comb begin
        cap_pos        = r_pos;
        cap_ether_type = r_ether_type;
        cap_ihl        = r_ihl;
        cap_proto      = r_proto;
        cap_dport      = r_dport;
        if (r_pos < POS_MAX) begin
            cap_pos = r_pos + 6'd1;
            unique case (r_pos)
                POS_ETYPE_HI: cap_ether_type[15:8] = i_item.frame_byte;
                POS_ETYPE_LO: cap_ether_type[7:0]  = i_item.frame_byte;
                POS_IHL:      cap_ihl              = i_item.frame_byte[3:0];
                POS_PROTO:    cap_proto            = i_item.frame_byte;
                POS_DPORT_HI: cap_dport[15:8]      = i_item.frame_byte;
                POS_DPORT_LO: cap_dport[7:0]       = i_item.frame_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        frame_ok = (cap_pos >= MIN_FRAME_LEN) && (cap_ether_type == ETHERTYPE_IPV4)
                && (cap_proto == PROTO_UDP) && (cap_ihl == IHL_PLAIN);

        o_event.queue    = i_item.rx_queue;
        o_event.queue_ok = ({3'b000, i_item.rx_queue} < QUEUE_LIMIT);
        if (!frame_ok) begin
            o_event.cls = CLS_UNCOUNTED;
        end else if (cap_dport != r_match_port) begin
            o_event.cls = CLS_MISMATCH;
        end else begin
            o_event.cls = CLS_MATCH;
        end
        o_push = i_accept && i_item.last_byte;
    end

    always_comb begin
        n_pos        = r_pos;
        n_ether_type = r_ether_type;
        n_ihl        = r_ihl;
        n_proto      = r_proto;
        n_dport      = r_dport;
        if (i_accept) begin
            if (i_item.last_byte) begin
                n_pos        = '0;
                n_ether_type = '0;
                n_ihl        = '0;
                n_proto      = '0;
                n_dport      = '0;
            end else begin
                n_pos        = cap_pos;
                n_ether_type = cap_ether_type;
                n_ihl        = cap_ihl;
                n_proto      = cap_proto;
                n_dport      = cap_dport;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_port <= '0;
            r_pos        <= '0;
            r_ether_type <= '0;
            r_ihl        <= '0;
            r_proto      <= '0;
            r_dport      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_match_port <= i_cfg_wr_data;
            end
            r_pos        <= n_pos;
            r_ether_type <= n_ether_type;
            r_ihl        <= n_ihl;
            r_proto      <= n_proto;
            r_dport      <= n_dport;
        end
    end

endmodule

// ===== design/ufc_evq.sv =====
module ufc_evq
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_event      i_event,
    input  logic        i_pop,
    output t_event      o_event,
    output t_evq_status o_status
);

    t_event                 r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [EVQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [EVQ_COUNT_W-1:0] r_count, n_count;
    logic                   do_push, do_pop;

    localparam logic [EVQ_COUNT_W-1:0] DEPTH_C = EVQ_COUNT_W'(EVQ_DEPTH);
    localparam logic [EVQ_PTR_W-1:0]   LAST_C  = EVQ_PTR_W'(EVQ_DEPTH - 1);

    always_comb begin
        o_status.valid = (r_count != '0);
        o_status.full  = (r_count == DEPTH_C);
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && o_status.valid;
        o_event = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("event queue overfilled");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == DEPTH_C) |-> (r_wr_ptr == r_rd_ptr))
        else $error("event queue pointers out of step with count");

    a_push_pop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && do_pop) |=> (r_count == $past(r_count)))
        else $error("simultaneous push and pop changed count");

endmodule

// ===== design/ufc_back.sv =====
module ufc_back
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_event      i_event,
    input  t_evq_status i_evq,
    output logic        o_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    logic        r_valid, n_valid;
    logic [63:0] r_redir_cnt, n_redir_cnt;
    logic [63:0] r_mism_cnt, n_mism_cnt;
    logic        r_verdict, n_verdict;
    logic [5:0]  r_target, n_target;

    always_comb begin
        o_pop       = i_evq.valid && (!r_valid || !i_out_stall);
        n_valid     = r_valid && i_out_stall;
        n_redir_cnt = r_redir_cnt;
        n_mism_cnt  = r_mism_cnt;
        n_verdict   = r_verdict;
        n_target    = r_target;
        if (o_pop) begin
            n_valid   = 1'b1;
            n_verdict = 1'b0;
            n_target  = '0;
            case (i_event.cls)
                CLS_MISMATCH: n_mism_cnt = r_mism_cnt + 64'd1;
                CLS_MATCH: begin
                    n_redir_cnt = r_redir_cnt + 64'd1;
                    // no such queue: still counted, but the frame passes
                    if (i_event.queue_ok) begin
                        n_verdict = 1'b1;
                        n_target  = i_event.queue;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_redir_cnt <= '0;
            r_mism_cnt  <= '0;
        end else begin
            r_valid     <= n_valid;
            r_redir_cnt <= n_redir_cnt;
            r_mism_cnt  <= n_mism_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        r_target  <= n_target;
    end

    always_comb begin
        o_out_valid                 = r_valid;
        o_out_data.verdict          = r_verdict;
        o_out_data.target_queue     = r_target;
        o_out_data.redirected_count = r_redir_cnt;
        o_out_data.mismatch_count   = r_mism_cnt;
    end

    a_no_pop_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |-> !o_pop)
        else $error("popped an event while result was stalled");

    a_redir_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_redir_cnt) |-> $past(o_pop) && (r_redir_cnt == $past(r_redir_cnt) + 64'd1))
        else $error("redirect counter moved without a match");

    a_mism_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_mism_cnt) |-> $past(o_pop) && (r_mism_cnt == $past(r_mism_cnt) + 64'd1))
        else $error("mismatch counter moved without a mismatch");

endmodule

// ===== design/udp_port_frame_classifier_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item, one frame byte)
// out       output     o_out_valid / i_out_stall  o_out_data (t_out_item, one per frame)
// cfg       input      i_cfg_wr_en                i_cfg_wr_data (match_port)
//
// One frame byte is taken every cycle while o_in_stall is low; the parser finishes
// a frame on its last byte. The edge that takes the last byte writes the event queue;
// the output register pops it, making the verdict valid, when empty or not stalled.
// o_in_stall rises only when the two-entry event queue is full, i.e. two verdicts
// wait behind a stalled output.
// Synchronous active-low reset clears the parser, counters and match_port.
module udp_port_frame_classifier_top
    import ufc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    logic        in_accept;
    logic        push;
    logic        pop;
    t_event      front_event;
    t_event      queued_event;
    t_evq_status evq_status;

    assign o_in_stall = evq_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    ufc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_item        (i_in_data),
        .o_push        (push),
        .o_event       (front_event)
    );

    ufc_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_event  (front_event),
        .i_pop    (pop),
        .o_event  (queued_event),
        .o_status (evq_status)
    );

    ufc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_event     (queued_event),
        .i_evq       (evq_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== verif/tb_udp_port_frame_classifier_top.sv =====
`timescale 1ns / 100ps

module tb_udp_port_frame_classifier_top
    import ufc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;

    // Reference for frame parsing and verdicts, plus the verdicts still owed by the DUT
    class verdict_scoreboard;
        logic [15:0] match_port = '0;
        logic [5:0]  byte_pos = '0;
        logic [15:0] ether_type = '0;
        logic [3:0]  ihl = '0;
        logic [7:0]  proto = '0;
        logic [15:0] dport = '0;
        logic [63:0] redirects = '0;
        logic [63:0] mismatches = '0;
        t_out_item   pending_verdicts[$];
        int          n_fail = 0;
        int          n_frames = 0;
        int          n_redirected = 0;
        int          n_checked = 0;

        function void classify_byte(t_in_item it);
            t_out_item want;
            if (byte_pos < POS_MAX) begin
                case (byte_pos)
                    POS_ETYPE_HI: ether_type[15:8] = it.frame_byte;
                    POS_ETYPE_LO: ether_type[7:0] = it.frame_byte;
                    POS_IHL:      ihl = it.frame_byte[3:0];
                    POS_PROTO:    proto = it.frame_byte;
                    POS_DPORT_HI: dport[15:8] = it.frame_byte;
                    POS_DPORT_LO: dport[7:0] = it.frame_byte;
                    default: ;
                endcase
                byte_pos = byte_pos + 6'd1;
            end
            if (it.last_byte) begin
                want = '0;
                if (byte_pos >= MIN_FRAME_LEN && ether_type == ETHERTYPE_IPV4 &&
                    proto == PROTO_UDP && ihl == IHL_PLAIN) begin
                    if (dport != match_port) begin
                        mismatches = mismatches + 64'd1;
                    end else begin
                        redirects = redirects + 64'd1;
                        if ({3'b000, it.rx_queue} < QUEUE_LIMIT) begin
                            want.verdict = 1'b1;
                            want.target_queue = it.rx_queue;
                            n_redirected++;
                        end
                    end
                end
                want.redirected_count = redirects;
                want.mismatch_count = mismatches;
                pending_verdicts.push_back(want);
                n_frames++;
                byte_pos = '0;
                ether_type = '0;
                ihl = '0;
                proto = '0;
                dport = '0;
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                n_fail++;
            end
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict with none pending, expected nothing, actual %h",
                         $time, got);
                n_fail++;
                return;
            end
            want = pending_verdicts.pop_front();
            n_checked++;
            check_field("verdict", 64'(want.verdict), 64'(got.verdict));
            check_field("target_queue", 64'(want.target_queue), 64'(got.target_queue));
            check_field("redirected_count", want.redirected_count, got.redirected_count);
            check_field("mismatch_count", want.mismatch_count, got.mismatch_count);
        endfunction
    endclass

    verdict_scoreboard sb = new();

    logic [7:0]  frame_bytes[$];
    int          bytes_sent = 0;
    bit          idle_on = 1'b1;
    int          hold_cycles = 0;
    int          cycle_count = 0;

    udp_port_frame_classifier_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d verdicts still pending",
                     $time, sb.pending_verdicts.size());
            $display("[udp_port_frame_classifier_top] ERROR");
            $finish;
        end
    end

    task automatic send_byte(t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.classify_byte(it);
        bytes_sent++;
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones; header fields land only where the frame reaches
    task automatic make_frame(int len, logic [15:0] etype, logic [7:0] ihl_byte,
                              logic [7:0] prot, logic [15:0] port, int fill);
        frame_bytes.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                1: frame_bytes.push_back(8'h00);
                2: frame_bytes.push_back(8'hFF);
                default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (len > POS_ETYPE_HI) frame_bytes[POS_ETYPE_HI] = etype[15:8];
        if (len > POS_ETYPE_LO) frame_bytes[POS_ETYPE_LO] = etype[7:0];
        if (len > POS_IHL)      frame_bytes[POS_IHL] = ihl_byte;
        if (len > POS_PROTO)    frame_bytes[POS_PROTO] = prot;
        if (len > POS_DPORT_HI) frame_bytes[POS_DPORT_HI] = port[15:8];
        if (len > POS_DPORT_LO) frame_bytes[POS_DPORT_LO] = port[7:0];
    endtask

    task automatic send_frame(logic [5:0] queue);
        t_in_item it;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            it.frame_byte = frame_bytes[i];
            it.last_byte = (i == frame_bytes.size() - 1);
            // queue only matters on the last byte; toggle it everywhere anyway
            it.rx_queue = it.last_byte ? queue : 6'($urandom_range(0, 63));
            send_byte(it);
        end
    endtask

    task automatic random_frame();
        int          pick;
        int          len;
        logic [15:0] port;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 90) : $urandom_range(42, 63);
        case ($urandom_range(0, 3))
            0: port = 16'($urandom_range(0, 65535));
            1: port = sb.match_port ^ (16'd1 << $urandom_range(0, 15));
            default: port = sb.match_port;
        endcase
        if (pick < 60)
            make_frame(len, ETHERTYPE_IPV4, {4'($urandom_range(0, 15)), IHL_PLAIN},
                       PROTO_UDP, port, 0);
        else if (pick < 70)
            make_frame($urandom_range(1, 41), ETHERTYPE_IPV4, 8'h45, PROTO_UDP, port, 0);
        else if (pick < 77)
            make_frame(len, ($urandom_range(0, 1) ? 16'h0806 : 16'($urandom_range(0, 65535))),
                       8'h45, PROTO_UDP, port, 0);
        else if (pick < 84)
            make_frame(len, ETHERTYPE_IPV4, 8'h45, 8'($urandom_range(0, 255)), port, 0);
        else if (pick < 91)
            make_frame(len, ETHERTYPE_IPV4, 8'($urandom_range(0, 255)), PROTO_UDP, port, 0);
        else
            make_frame($urandom_range(1, 90), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 0);
        send_frame(6'($urandom_range(0, 63)));
    endtask

    // Drain all verdicts, give the pipeline time to empty, then write match_port
    task automatic drain_and_set_port(logic [15:0] port);
        in_valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= port;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.match_port = port;
    endtask

    initial begin : receiver
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end else begin
                gap = idle_on ? $urandom_range(0, 3) : 0;
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    out_stall <= 1'b0;
                end
            end
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            sb.check_verdict(out_data);
        end
    end

    initial begin : stimulus
        logic [15:0] phase_port[PHASE_COUNT];
        logic [15:0] mp;
        int          start_bytes;
        int          start_frames;

        phase_port[0] = 16'hFFFF;
        phase_port[1] = 16'h0000;
        phase_port[2] = 16'($urandom_range(1, 65534));
        phase_port[3] = 16'($urandom_range(1, 65534));
        phase_port[4] = 16'h8000;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames
        mp = 16'h0035;
        drain_and_set_port(mp);
        make_frame(1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 2);
        send_frame(6'd63);
        make_frame(41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 1);   // one byte short
        send_frame(6'd5);
        make_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 2);
        send_frame(6'd0);
        make_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 1);
        send_frame(6'd63);
        make_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp ^ 16'h0001, 0);
        send_frame(6'd17);
        make_frame(42, 16'h86DD, 8'h45, PROTO_UDP, mp, 0);
        send_frame(6'd9);
        make_frame(42, 16'h0008, 8'h45, PROTO_UDP, mp, 0);   // swapped EtherType bytes
        send_frame(6'd9);
        make_frame(42, ETHERTYPE_IPV4, 8'h45, 8'd6, mp, 0);
        send_frame(6'd33);
        make_frame(42, ETHERTYPE_IPV4, 8'h46, PROTO_UDP, mp, 0);
        send_frame(6'd33);
        make_frame(42, ETHERTYPE_IPV4, 8'hF5, PROTO_UDP, mp, 2);   // version nibble is ignored
        send_frame(6'd21);
        make_frame(63, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 0);
        send_frame(6'd42);
        make_frame(64, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 0);
        send_frame(6'd42);
        make_frame(90, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, mp, 0);   // position saturates
        send_frame(6'd42);

        // Random phases, one match_port each
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_and_set_port(phase_port[ph]);
            idle_on = (ph != 3);
            start_bytes = bytes_sent;
            start_frames = sb.n_frames;
            if (ph == 1) begin
                // receiver holds off while tiny frames pile up behind it
                hold_cycles = HOLD_CYCLES;
                repeat (10) begin
                    make_frame($urandom_range(1, 3), ETHERTYPE_IPV4, 8'h45, PROTO_UDP,
                               phase_port[ph], 0);
                    send_frame(6'($urandom_range(0, 63)));
                end
            end
            while (bytes_sent - start_bytes < 40 || sb.n_frames - start_frames < 1)
                random_frame();
        end

        in_valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d frames in %0d bytes over %0d match ports; %0d verdicts checked.",
                 sb.n_frames, bytes_sent, PHASE_COUNT + 1, sb.n_checked);
        $display("Redirects %0d, port mismatches counted %0d, failures %0d.",
                 sb.n_redirected, sb.mismatches, sb.n_fail);
        if (sb.n_fail == 0)
            $display("[udp_port_frame_classifier_top] OK");
        else
            $display("[udp_port_frame_classifier_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/ufc_pkg.sv
design/ufc_front.sv
design/ufc_evq.sv
design/ufc_back.sv
design/udp_port_frame_classifier_top.sv
verif/tb_udp_port_frame_classifier_top.sv
